/* rtl/ffa_pkg.sv */
// Shared types and codes for the first-fit extent allocator.
// No dependencies.
package ffa_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOGAP = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADH  = 2'd3;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  localparam logic REG_DISK_SIZE  = 1'b0;
  localparam logic REG_DATA_START = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_PLACE   = 3'd1,
    ACT_NOGAP   = 3'd2,
    ACT_FULL    = 3'd3,
    ACT_ADVANCE = 3'd4,
    ACT_RELEASE = 3'd5,
    ACT_BADH    = 3'd6,
    ACT_RELOAD  = 3'd7
  } ffa_act_t;

  typedef struct packed {
    logic     rd_en;
    logic     hsel;
    logic     scan;
    logic     reload;
    logic     slot_chk;
    logic     item_init;
    logic     pass_init;
    logic     rl_init;
    ffa_act_t act;
  } ffa_cmd_t;

  typedef struct packed {
    logic got_slot;
    logic found;
    logic gap_fit;
    logic end_fit;
    logic hval;
  } ffa_sts_t;

endpackage

/* rtl/ffa_if.sv */
// Channel interfaces for allocator requests and results.
// Depends on nothing.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] length;
  logic [5:0]  handle;
  modport source (output valid, action, length, handle, input ready);
  modport sink (input valid, action, length, handle, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] extent_begin;
  logic [5:0]  new_handle;
  logic [31:0] free_bytes;
  logic [6:0]  extents_in_use;
  modport source (output valid, status, extent_begin, new_handle, free_bytes, extents_in_use,
                  input ready);
  modport sink (input valid, status, extent_begin, new_handle, free_bytes, extents_in_use,
                output ready);
endinterface

/* rtl/ffa_ctrl.sv */
// Sequencer for the allocator: table walks, free, reload, result commit.
// Depends on ffa_pkg.
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr,
  input  logic                           in_valid,
  input  logic                           in_action,
  input  logic                           out_ready,
  input  ffa_sts_t                       sts,
  output ffa_cmd_t                       cmd,
  output logic [$clog2(MAX_EXTENTS)-1:0] rd_idx,
  output logic                           in_ready,
  output logic                           out_valid
);

  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam logic [IW-1:0] LAST = IW'(MAX_EXTENTS - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_DRAIN   = 9'b000000100,
    S_STEP    = 9'b000001000,
    S_FREE_RD = 9'b000010000,
    S_FREE_WB = 9'b000100000,
    S_RELOAD  = 9'b001000000,
    S_RDRAIN  = 9'b010000000,
    S_RFIN    = 9'b100000000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic          first, first_next;
  logic          out_free, commit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !cfg_wr;
  assign rd_idx   = idx;
  assign commit   = (cmd.act == ACT_PLACE) || (cmd.act == ACT_NOGAP) ||
                    (cmd.act == ACT_FULL) || (cmd.act == ACT_RELEASE) ||
                    (cmd.act == ACT_BADH);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    first_next = first;
    cmd        = '0;
    cmd.act    = ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (cfg_wr) begin
          state_next = S_RELOAD;
          idx_next   = '0;
        end else if (in_valid) begin
          cmd.item_init = 1'b1;
          idx_next      = '0;
          first_next    = 1'b1;
          state_next    = (in_action == ACTION_FREE) ? S_FREE_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.scan     = 1'b1;
        cmd.slot_chk = first;
        idx_next     = idx + 1'b1;
        if (idx == LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        if (first && !sts.got_slot) begin
          if (out_free) begin
            cmd.act    = ACT_FULL;
            state_next = S_IDLE;
          end
        end else if (!sts.found) begin
          if (out_free) begin
            cmd.act    = sts.end_fit ? ACT_PLACE : ACT_NOGAP;
            state_next = S_IDLE;
          end
        end else if (sts.gap_fit) begin
          if (out_free) begin
            cmd.act    = ACT_PLACE;
            state_next = S_IDLE;
          end
        end else begin
          cmd.act       = ACT_ADVANCE;
          cmd.pass_init = 1'b1;
          first_next    = 1'b0;
          idx_next      = '0;
          state_next    = S_SCAN;
        end
      end
      S_FREE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.hsel   = 1'b1;
        state_next = S_FREE_WB;
      end
      S_FREE_WB: begin
        if (out_free) begin
          cmd.act    = sts.hval ? ACT_RELEASE : ACT_BADH;
          state_next = S_IDLE;
        end
      end
      S_RELOAD: begin
        cmd.rd_en   = 1'b1;
        cmd.reload  = 1'b1;
        cmd.rl_init = (idx == '0);
        idx_next    = idx + 1'b1;
        if (idx == LAST) begin
          state_next = S_RDRAIN;
        end
        if (cfg_wr) begin
          idx_next   = '0;
          state_next = S_RELOAD;
        end
      end
      S_RDRAIN: begin
        state_next = S_RFIN;
        if (cfg_wr) begin
          idx_next   = '0;
          state_next = S_RELOAD;
        end
      end
      S_RFIN: begin
        if (cfg_wr) begin
          idx_next   = '0;
          state_next = S_RELOAD;
        end else begin
          cmd.act    = ACT_RELOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      first <= first_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/ffa_dp.sv */
// Allocator datapath: extent tables, config registers, gap search, counts.
// Depends on ffa_pkg.
module ffa_dp
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffa_cmd_t                       cmd,
  input  logic [$clog2(MAX_EXTENTS)-1:0] rd_idx,
  output ffa_sts_t                       sts,
  input  logic                           cfg_wr,
  input  logic                           cfg_sel,
  input  logic [31:0]                    cfg_data,
  output logic [31:0]                    disk_size_rd,
  output logic [31:0]                    data_start_rd,
  input  logic [31:0]                    in_length,
  input  logic [5:0]                     in_handle,
  output logic [1:0]                     status,
  output logic [31:0]                    extent_begin,
  output logic [5:0]                     new_handle,
  output logic [31:0]                    free_bytes,
  output logic [6:0]                     extents_in_use
);

  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  typedef logic [ADDR_BITS-1:0] addr_t;

  function automatic addr_t to_addr(input logic [31:0] v);
    logic [ADDR_BITS+31:0] t;
    t = {{ADDR_BITS{1'b0}}, v};
    return t[ADDR_BITS-1:0];
  endfunction

  function automatic logic [31:0] to32(input addr_t v);
    logic [ADDR_BITS+31:0] t;
    t = {32'd0, v};
    return t[31:0];
  endfunction

  function automatic addr_t sat_add(input addr_t a, input addr_t b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? '1 : s[ADDR_BITS-1:0];
  endfunction

  addr_t disk_size, data_start;
  addr_t mem_b [MAX_EXTENTS];
  addr_t mem_l [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] valid;

  addr_t         b_d, l_d;
  logic          vb_d, scan_d, rl_d;
  logic [IW-1:0] idx_d;

  addr_t         len, cur, last_b, best_b, best_l, f_acc, sum_end;
  logic [5:0]    hnd;
  logic [IW-1:0] last_s, best_s, slot, h_idx, ridx;
  logic          have_last, found, got;
  logic [31:0]   free_cnt, free_next, len32, l32;
  logic [32:0]   rel_sum;
  logic [CW-1:0] used, used_next;
  logic [IW+5:0] hx, sx;
  logic [CW+6:0] ux;
  logic          cand, take, h_in_range;
  logic          fit_gap_a, fit_end_a;

  assign hx    = {{IW{1'b0}}, hnd};
  assign h_idx = hx[IW-1:0];
  assign ridx  = cmd.hsel ? h_idx : rd_idx;
  assign h_in_range = (32'(hnd) < 32'(MAX_EXTENTS));

  assign disk_size_rd  = to32(disk_size);
  assign data_start_rd = to32(data_start);

  assign sum_end   = sat_add(cur, len);
  assign fit_gap_a = (best_b >= cur) && ((best_b - cur) >= len) &&
                     (sum_end <= disk_size) && (cur <= disk_size);
  assign fit_end_a = (disk_size >= cur) && ((disk_size - cur) >= len) &&
                     (sum_end <= disk_size);

  assign sts.got_slot = got;
  assign sts.found    = found;
  assign sts.gap_fit  = found && fit_gap_a;
  assign sts.end_fit  = fit_end_a;
  assign sts.hval     = h_in_range && valid[h_idx];

  assign cand = scan_d && vb_d &&
                (!have_last || (b_d > last_b) || ((b_d == last_b) && (idx_d > last_s)));
  assign take = cand && (!found || (b_d < best_b));

  assign len32   = to32(len);
  assign l32     = to32(l_d);
  assign rel_sum = {1'b0, free_cnt} + {1'b0, l32};

  always_comb begin
    free_next = free_cnt;
    used_next = used;
    case (cmd.act)
      ACT_PLACE: begin
        free_next = (free_cnt >= len32) ? (free_cnt - len32) : 32'd0;
        used_next = used + 1'b1;
      end
      ACT_RELEASE: begin
        free_next = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
        used_next = (used != '0) ? (used - 1'b1) : used;
      end
      default: begin
        free_next = free_cnt;
        used_next = used;
      end
    endcase
  end

  assign sx = {6'd0, slot};
  assign ux = {7'd0, used_next};

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_PLACE) begin
      mem_b[slot] <= cur;
      mem_l[slot] <= len;
    end
    if (cmd.rd_en) begin
      b_d <= mem_b[ridx];
      l_d <= mem_l[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size  <= '0;
      data_start <= '0;
      valid      <= '0;
      free_cnt   <= '0;
      used       <= '0;
      scan_d     <= 1'b0;
      rl_d       <= 1'b0;
      have_last  <= 1'b0;
      found      <= 1'b0;
      got        <= 1'b0;
    end else begin
      scan_d <= cmd.rd_en && cmd.scan;
      rl_d   <= cmd.rd_en && cmd.reload;
      if (cfg_wr) begin
        if (cfg_sel == REG_DATA_START) begin
          data_start <= to_addr(cfg_data);
        end else begin
          disk_size <= to_addr(cfg_data);
        end
      end
      if (cmd.item_init) begin
        have_last <= 1'b0;
        found     <= 1'b0;
        got       <= 1'b0;
      end
      if (cmd.pass_init) begin
        found <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (cmd.slot_chk && !got && !valid[ridx]) begin
        got <= 1'b1;
      end
      if (cmd.act == ACT_ADVANCE) begin
        have_last <= 1'b1;
      end
      if (cmd.act == ACT_PLACE) begin
        valid[slot] <= 1'b1;
      end
      if (cmd.act == ACT_RELEASE) begin
        valid[h_idx] <= 1'b0;
      end
      if (cmd.act == ACT_RELOAD) begin
        free_cnt <= to32(f_acc);
      end else begin
        free_cnt <= free_next;
      end
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    vb_d  <= valid[ridx];
    idx_d <= ridx;
    if (cmd.item_init) begin
      len <= to_addr(in_length);
      hnd <= in_handle;
      cur <= data_start;
    end
    if (take) begin
      best_b <= b_d;
      best_l <= l_d;
      best_s <= idx_d;
    end
    if (cmd.slot_chk && !got && !valid[ridx]) begin
      slot <= ridx;
    end
    if (cmd.act == ACT_ADVANCE) begin
      if (sat_add(best_b, best_l) > cur) begin
        cur <= sat_add(best_b, best_l);
      end
      last_b <= best_b;
      last_s <= best_s;
    end
    if (cmd.rl_init) begin
      f_acc <= (disk_size >= data_start) ? (disk_size - data_start) : '0;
    end else if (rl_d && vb_d) begin
      f_acc <= (f_acc >= l_d) ? (f_acc - l_d) : '0;
    end
    case (cmd.act)
      ACT_PLACE, ACT_NOGAP, ACT_FULL, ACT_RELEASE, ACT_BADH: begin
        extent_begin   <= (cmd.act == ACT_PLACE) ? to32(cur) : 32'd0;
        new_handle     <= (cmd.act == ACT_PLACE) ? sx[5:0] : 6'd0;
        free_bytes     <= free_next;
        extents_in_use <= ux[6:0];
        case (cmd.act)
          ACT_PLACE, ACT_RELEASE: status <= ST_OK;
          ACT_NOGAP:              status <= ST_NOGAP;
          ACT_FULL:               status <= ST_FULL;
          default:                status <= ST_BADH;
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/first_fit_extent_allocator.sv */
// First-fit extent allocator, top level: APB config port, request/result channels.
// Allocate: walks the table one entry per cycle through the single memory read port,
// in 1 + (extents passed before the fit) passes. Free: reads the entry of the handle,
// then commits the result. A config write reloads the free count by a walk of the table.
// One transaction at a time; a result waits in an output register.
// Reset (rst, synchronous): empty table, zero counts, disk_size and data_start zero.
module first_fit_extent_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  ffa_req_if.sink               req,
  ffa_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ffa_cmd_t                       cmd;
  ffa_sts_t                       sts;
  logic [$clog2(MAX_EXTENTS)-1:0] rd_idx;
  logic                           cfg_wr;
  logic [31:0]                    disk_size_rd, data_start_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DATA_START) ? data_start_rd : disk_size_rd;

  ffa_ctrl #(.MAX_EXTENTS(MAX_EXTENTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_valid  (req.valid),
    .in_action (req.action),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .in_ready  (req.ready),
    .out_valid (rsp.valid)
  );

  ffa_dp #(.MAX_EXTENTS(MAX_EXTENTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_idx         (rd_idx),
    .sts            (sts),
    .cfg_wr         (cfg_wr),
    .cfg_sel        (paddr[2]),
    .cfg_data       (pwdata),
    .disk_size_rd   (disk_size_rd),
    .data_start_rd  (data_start_rd),
    .in_length      (req.length),
    .in_handle      (req.handle),
    .status         (rsp.status),
    .extent_begin   (rsp.extent_begin),
    .new_handle     (rsp.new_handle),
    .free_bytes     (rsp.free_bytes),
    .extents_in_use (rsp.extents_in_use)
  );

endmodule

/* rtl/ffa_chk.sv */
// Port-level checks for the first-fit extent allocator, bound to the top level.
// Depends on ffa_pkg.
module ffa_chk
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [31:0] extent_begin,
  input logic [5:0]  new_handle,
  input logic [6:0]  extents_in_use
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("stalled result dropped or changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (extent_begin == 32'd0) && (new_handle == 6'd0))
    else $error("error result carries placement");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(extents_in_use) <= 32'(MAX_EXTENTS)))
    else $error("extent count above table size");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new transaction taken while busy");

endmodule

bind first_fit_extent_allocator ffa_chk #(.MAX_EXTENTS(MAX_EXTENTS)) u_ffa_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .extent_begin   (rsp.extent_begin),
  .new_handle     (rsp.new_handle),
  .extents_in_use (rsp.extents_in_use)
);

/* dv/ffa_scoreboard.sv */
`timescale 1ns / 1ps
// Checker for the first-fit extent allocator: tracks APB writes, predicts each result
// on request acceptance and compares it with the result channel. Depends on ffa_pkg, ffa_if.
module ffa_scoreboard
  import ffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ffa_req_if                    req_mon,
  ffa_rsp_if                    rsp_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);

  localparam int NSLOT = 64;
  localparam logic [63:0] TOP = 64'hFFFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] extent_begin;
    logic [5:0]  new_handle;
    logic [31:0] free_bytes;
    logic [6:0]  extents_in_use;
  } alloc_result_t;

  logic [63:0]   disk_size, data_start;
  logic [63:0]   ext_begin [NSLOT];
  logic [63:0]   ext_len [NSLOT];
  bit            in_use [NSLOT];
  logic [63:0]   free_cnt;
  logic [6:0]    used_cnt;
  alloc_result_t awaited [$];

  assign pending = awaited.size();

  function automatic logic [63:0] end_of(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TOP) ? TOP : s;
  endfunction

  function automatic bit gap_ok(logic [63:0] cur, logic [63:0] lim, logic [63:0] ln);
    if (lim < cur || lim - cur < ln) return 0;
    return end_of(cur, ln) <= disk_size && cur <= disk_size;
  endfunction

  function automatic void recount_free();
    logic [63:0] f;
    f = (disk_size >= data_start) ? disk_size - data_start : 0;
    for (int i = 0; i < NSLOT; i++)
      if (in_use[i]) f = (f >= ext_len[i]) ? f - ext_len[i] : 0;
    free_cnt = f & TOP;
  endfunction

  function automatic bit first_fit(logic [63:0] ln, output logic [63:0] where);
    logic [63:0] cur, last_b, best_b, e;
    int          last_s, best_s;
    bit          have_last, found;
    cur = data_start;
    have_last = 0;
    last_b = 0;
    last_s = 0;
    where = 0;
    for (int n = 0; n <= NSLOT; n++) begin
      found = 0;
      best_b = 0;
      best_s = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!in_use[i]) continue;
        if (have_last && !(ext_begin[i] > last_b || (ext_begin[i] == last_b && i > last_s)))
          continue;
        if (!found || ext_begin[i] < best_b) begin
          found = 1;
          best_b = ext_begin[i];
          best_s = i;
        end
      end
      if (!found) break;
      if (best_b >= cur && gap_ok(cur, best_b, ln)) begin
        where = cur;
        return 1;
      end
      e = end_of(best_b, ext_len[best_s]);
      if (e > cur) cur = e;
      have_last = 1;
      last_b = best_b;
      last_s = best_s;
    end
    if (gap_ok(cur, disk_size, ln)) begin
      where = cur;
      return 1;
    end
    return 0;
  endfunction

  function automatic alloc_result_t apply_request(logic act, logic [31:0] ln, logic [5:0] h);
    alloc_result_t r;
    logic [63:0]   where, f;
    int            slot;
    r = '{ST_OK, 32'd0, 6'd0, 32'd0, 7'd0};
    if (act == ACTION_ALLOC) begin
      slot = -1;
      for (int i = NSLOT - 1; i >= 0; i--)
        if (!in_use[i]) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
      end else if (!first_fit({32'd0, ln}, where)) begin
        r.status = ST_NOGAP;
      end else begin
        ext_begin[slot] = where;
        ext_len[slot] = {32'd0, ln};
        in_use[slot] = 1;
        used_cnt++;
        free_cnt = (free_cnt >= ln) ? free_cnt - ln : 0;
        r.extent_begin = where[31:0];
        r.new_handle = slot[5:0];
      end
    end else begin
      if (!in_use[h]) begin
        r.status = ST_BADH;
      end else begin
        f = free_cnt + ext_len[h];
        in_use[h] = 0;
        if (used_cnt > 0) used_cnt--;
        free_cnt = (f > TOP) ? TOP : f;
      end
    end
    r.free_bytes = free_cnt[31:0];
    r.extents_in_use = used_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst) begin
      disk_size = 0;
      data_start = 0;
      free_cnt = 0;
      used_cnt = 0;
      for (int i = 0; i < NSLOT; i++) in_use[i] = 0;
      awaited.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_DISK_SIZE, 2'b00}) begin
          disk_size = {32'd0, pwdata};
          recount_free();
        end else if (paddr == {REG_DATA_START, 2'b00}) begin
          data_start = {32'd0, pwdata};
          recount_free();
        end
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          exp_r = awaited.pop_front();
          if (rsp_mon.status !== exp_r.status || rsp_mon.extent_begin !== exp_r.extent_begin
              || rsp_mon.new_handle !== exp_r.new_handle
              || rsp_mon.free_bytes !== exp_r.free_bytes
              || rsp_mon.extents_in_use !== exp_r.extents_in_use) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: exp st=%0d beg=%h h=%0d free=%h used=%0d, got st=%0d beg=%h h=%0d free=%h used=%0d",
                       $realtime, exp_r.status, exp_r.extent_begin, exp_r.new_handle,
                       exp_r.free_bytes, exp_r.extents_in_use, rsp_mon.status,
                       rsp_mon.extent_begin, rsp_mon.new_handle, rsp_mon.free_bytes,
                       rsp_mon.extents_in_use);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited.push_back(apply_request(req_mon.action, req_mon.length, req_mon.handle));
    end
  end

endmodule

/* dv/first_fit_extent_allocator_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the first-fit extent allocator: clock, reset, APB writes and
// request/result traffic; checking lives in ffa_scoreboard. Depends on ffa_pkg, ffa_if.
module first_fit_extent_allocator_tb;
  import ffa_pkg::*;

  localparam longint CYCLE_LIMIT = 60_000_000;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    errors, pending;
  int                    tx_idle = 0, rx_idle = 0;
  bit                    hold_req = 0;
  bit                    hold_done = 0;
  int                    hold_left = 0;
  longint                cycles = 0;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();

  first_fit_extent_allocator dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ffa_scoreboard chk (
    .clk(clk), .rst(rst), .req_mon(req_ch), .rsp_mon(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.action = ACTION_ALLOC;
    req_ch.length = '0;
    req_ch.handle = '0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold off the result side once for a long stretch on request
  always @(negedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 400;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 0;
    end else begin
      rsp_ch.ready = ($urandom_range(0, 99) >= rx_idle);
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic reconfigure(logic [31:0] disk, logic [31:0] start);
    drain();
    reg_write(REG_DISK_SIZE, disk);
    reg_write(REG_DATA_START, start);
  endtask

  task automatic send(logic act, logic [31:0] ln, logic [5:0] h);
    while ($urandom_range(0, 99) < tx_idle) begin
      req_ch.valid = 0;
      @(negedge clk);
    end
    req_ch.valid = 1;
    req_ch.action = act;
    req_ch.length = ln;
    req_ch.handle = h;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 0;
  endtask

  task automatic send_random(int n, int alloc_pct, int unsigned max_len);
    logic        act;
    logic [31:0] ln;
    logic [5:0]  h;
    int          pick;
    for (int k = 0; k < n; k++) begin
      act = ($urandom_range(0, 99) < alloc_pct) ? ACTION_ALLOC : ACTION_FREE;
      pick = $urandom_range(0, 9);
      if (pick == 0) ln = 0;
      else if (pick == 1) ln = $urandom;
      else ln = $urandom_range(1, max_len);
      h = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(0, 15));
      send(act, ln, h);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty space after reset
    send(ACTION_ALLOC, 32'd0, 6'd0);
    send(ACTION_ALLOC, 32'd1, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd63);
    send(ACTION_FREE, 32'd0, 6'd0);
    reconfigure(32'd1000, 32'd100);
    send(ACTION_ALLOC, 32'd900, 6'd0);
    send(ACTION_ALLOC, 32'd1, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd0);
    send(ACTION_ALLOC, 32'd100, 6'd0);
    send(ACTION_ALLOC, 32'd200, 6'd0);
    send(ACTION_ALLOC, 32'd50, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd0);
    send(ACTION_ALLOC, 32'd100, 6'd0);
    send(ACTION_ALLOC, 32'd0, 6'd0);
    send(ACTION_ALLOC, 32'hFFFF_FFFF, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd2);
    reconfigure(32'hFFFF_FFFF, 32'd0);
    send(ACTION_ALLOC, 32'hFFFF_FFFF, 6'd0);
    send(ACTION_ALLOC, 32'd0, 6'd0);
    send(ACTION_FREE, 32'd0, 6'd3);
    send(ACTION_FREE, 32'd0, 6'd0);

    tx_idle = 18;
    rx_idle = 81;
    reconfigure(32'd4096, 32'd128);
    send_random(500, 55, 300);

    tx_idle = 81;
    rx_idle = 18;
    reconfigure(32'hFFFF_FFFF, 32'h100);
    hold_req = 1;
    send_random(20, 100, 64);
    hold_req = 0;
    send_random(480, 80, 4096);

    tx_idle = 0;
    rx_idle = 0;
    reconfigure(32'd200, 32'hFFFF_FFFF);
    send_random(100, 60, 50);
    reconfigure(32'd65536, 32'd0);
    send_random(400, 55, 8000);

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_ctrl.sv
rtl/ffa_dp.sv
rtl/first_fit_extent_allocator.sv
rtl/ffa_chk.sv
dv/ffa_scoreboard.sv
dv/first_fit_extent_allocator_tb.sv
